@@ hw/rtl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and the digit glyph table for the radix digit
// converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 64;
   localparam int STORE_DEPTH = 64;

   localparam int DIGIT_LIMIT = (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH :
                                ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] GLYPH_TABLE [16] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70
   };

   typedef struct packed {
      logic [63:0]        value;
      logic [RADIX_W-1:0] radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [RADIX_W-1:0]     radix;
   } div_ctl_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic                   quot_nz;
      logic [DIGIT_W-1:0]     remainder;
      logic [VALUE_WIDTH-1:0] quotient;
   } div_sts_type;

endpackage

@@ hw/rtl/rdc_ram.sv @@
// ----------------------------------------------------------------------------
// rdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Bit-serial restoring divider: one quotient bit per cycle, small radix
// divisor, narrow remainder.
// ----------------------------------------------------------------------------
module rdc_divider
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   nz_ff, nz_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;

   logic [RADIX_W-1:0]     trial;
   logic [RADIX_W-1:0]     diff;
   logic                   ge;

   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign ge    = (trial >= radix_ff);
   assign diff  = trial - radix_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      nz_in    = nz_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      if (ctl.start && !busy_ff) begin
         busy_in  = 1'b1;
         nz_in    = 1'b0;
         cnt_in   = '0;
         quo_in   = ctl.dividend;
         rem_in   = '0;
         radix_in = ctl.radix;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         rem_in = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         nz_in  = nz_ff | ge;
         cnt_in = cnt_ff + BIT_CNT_W'(1);
         if (cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      nz_ff    <= nz_in;
      cnt_ff   <= cnt_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign sts.busy      = busy_ff;
   assign sts.done      = done_ff;
   assign sts.quot_nz   = nz_ff;
   assign sts.remainder = rem_ff;
   assign sts.quotient  = quo_ff;

endmodule

@@ hw/rtl/radix_digit_converter_core.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an unsigned value to uppercase ASCII digits in radix 2..16,
// most significant digit first, last digit flagged.
//
//  channel  | dir | handshake            | payload
//  req_     | in  | req_valid/req_ready  | req_data  (value, radix)
//  rsp_     | out | rsp_valid/rsp_ready  | rsp_data  (digit_char, last_digit)
//
// Each digit comes from the bit-serial divider; the digits are then read back
// from the digit store in turn through ST_READ, ST_LOAD and ST_OUT, where a
// digit waits in ST_OUT until the sink raises rsp_ready.
// One item at a time; req_ready is high only while idle.
// Synchronous active-high reset; the digit store is not cleared.
// ----------------------------------------------------------------------------
module radix_digit_converter_core
   import rdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_READ = 5'b00100,
      ST_LOAD = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   div_ctl_type        div_ctl;
   div_sts_type        div_sts;

   logic               wr_en;
   logic               rd_en;
   logic [DIGIT_W-1:0] rd_data;
   logic [RADIX_W-1:0] radix_clamped;
   logic               room;

   always_comb begin
      if (req_data.radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_data.radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_data.radix;
      end
   end

   assign room = (count_ff < COUNT_W'(DIGIT_LIMIT));

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      radix_in         = radix_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = div_sts.quotient;
      div_ctl.radix    = radix_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = req_data.value[VALUE_WIDTH-1:0];
               div_ctl.radix    = radix_clamped;
               radix_in         = radix_clamped;
               count_in         = '0;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               wr_en = room;
               if (room) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               if (div_sts.quot_nz) begin
                  div_ctl.start = 1'b1;
               end else begin
                  idx_in   = ADDR_W'(count_in - COUNT_W'(1));
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_in.digit_char = GLYPH_TABLE[rd_data];
            rsp_in.last_digit = (idx_ff == '0);
            rsp_valid_in      = 1'b1;
            state_in          = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      radix_ff <= radix_in;
      rsp_ff   <= rsp_in;
   end

   rdc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (STORE_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_sts.remainder),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT))
      else $error("rsp_valid outside output state");

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_sts.busy)
      else $error("divider busy while idle");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DIGIT_LIMIT))
      else $error("digit count beyond limit");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_digit) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after last digit");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (count_ff != '0))
      else $error("digit read with empty store");
`endif

endmodule

@@ tb/sv/tb_radix_digit_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_radix_digit_converter_core
// Self-checking bench for the radix digit converter. Every accepted value is
// split into digits by a local predictor, and each digit transfer on the
// rsp_ channel is matched against the oldest pending digit. Covers the field
// extremes, radix clamping, random values with random gaps on both sides, a
// long sink hold-off and a pause until all digits have drained.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter_core;
   import rdc_pkg::*;

   localparam int  CLK_HALF      = 4;
   localparam int  RESET_CYCLES  = 5;
   localparam int  STALL_LIMIT   = 30000;
   localparam int  SETTLE_CYCLES = 20;
   localparam int  SINK_HOLD     = 6000;
   localparam int  RANDOM_ITEMS  = 105;
   localparam byte NUMERAL_BASE  = "0";
   localparam byte LETTER_BASE   = "A";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type digit_queue[$];
   bit      src_gaps = 1'b1;
   bit      sink_gaps = 1'b1;
   int      sink_hold = 0;
   int      idle_cycles = 0;
   int      errors = 0;
   int      values_taken = 0;
   int      digits_checked = 0;

   radix_digit_converter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // expected digits of one value, most significant first
   function automatic void predict_digits(input req_type item);
      logic [63:0]        rest;
      logic [RADIX_W-1:0] base;
      logic [3:0]         rems [STORE_DEPTH];
      int                 n;
      rsp_type            d;
      rest = item.value;
      base = item.radix;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      n = 0;
      do begin
         if (n < DIGIT_LIMIT) begin
            rems[n] = 4'(rest % base);
            n++;
         end
         rest = rest / base;
      end while (rest != 0);
      for (int k = n - 1; k >= 0; k--) begin
         d.digit_char = (rems[k] < 10) ? CHAR_W'(NUMERAL_BASE + rems[k])
                                       : CHAR_W'(LETTER_BASE + rems[k] - 10);
         d.last_digit = (k == 0);
         digit_queue.push_back(d);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_digits(req_data);
         values_taken++;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         digits_checked++;
         if (digit_queue.size() == 0) begin
            $error("unexpected digit transfer: digit_char %0d last_digit %0d",
                   rsp_data.digit_char, rsp_data.last_digit);
            errors++;
         end else begin
            want = digit_queue.pop_front();
            if (rsp_data.digit_char !== want.digit_char) begin
               $error("digit_char mismatch: expected %0d, got %0d",
                      want.digit_char, rsp_data.digit_char);
               errors++;
            end
            if (rsp_data.last_digit !== want.last_digit) begin
               $error("last_digit mismatch: expected %0d, got %0d",
                      want.last_digit, rsp_data.last_digit);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         rsp_ready <= 1'b0;
         sink_hold <= sink_hold - 1;
      end else if (sink_gaps) begin
         rsp_ready <= ($urandom_range(99) >= 20);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [63:0] v, input logic [RADIX_W-1:0] r);
      while (src_gaps && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: v, radix: r};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digit_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      int          bits;
      v = {$urandom, $urandom};
      if ($urandom_range(3) == 0) begin
         return v;
      end
      bits = $urandom_range(1, 32);
      return v & ({64{1'b1}} >> (64 - bits));
   endfunction

   function automatic logic [RADIX_W-1:0] rand_radix();
      if ($urandom_range(99) < 15) begin
         return RADIX_W'($urandom_range(31));
      end
      return RADIX_W'($urandom_range(2, 16));
   endfunction

   task automatic test_directed();
      send_item(64'd0, 5'd10);
      send_item(64'd0, 5'd2);
      send_item(64'd1, 5'd2);
      send_item('1, 5'd2);
      send_item('1, 5'd16);
      send_item('1, 5'd10);
      send_item('1, 5'd3);
      send_item(64'd5, 5'd0);
      send_item(64'd6, 5'd1);
      send_item(64'd255, 5'd17);
      send_item('1, 5'd31);
      send_item(64'd15, 5'd16);
      send_item(64'd10, 5'd11);
      send_item(64'd1 << 63, 5'd2);
      send_item(64'h0123_4567_89AB_CDEF, 5'd16);
      send_item(64'hFEDC_BA98_7654_3210, 5'd16);
      send_item(64'd1_000_000, 5'd10);
      send_item(64'd7, 5'd7);
      wait_drained();
   endtask

   task automatic test_random_values();
      src_gaps  <= 1'b0;
      sink_gaps <= 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 25) begin
            src_gaps  <= 1'b1;
            sink_gaps <= 1'b1;
         end
         send_item(rand_value(), rand_radix());
      end
      wait_drained();
   endtask

   // sink holds off long enough for the core to back up its input
   task automatic test_sink_holdoff();
      sink_hold <= SINK_HOLD;
      for (int i = 0; i < 6; i++) begin
         send_item(64'($urandom_range(65535)), RADIX_W'($urandom_range(2, 16)));
      end
      wait_drained();
   endtask

   task automatic test_pause_and_resume();
      for (int i = 0; i < 4; i++) begin
         send_item(rand_value(), rand_radix());
      end
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         send_item(rand_value(), rand_radix());
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_values();
      test_sink_holdoff();
      test_pause_and_resume();
      if (digit_queue.size() != 0) begin
         $error("%0d expected digits never arrived", digit_queue.size());
         errors++;
      end
      $display("converted %0d values into %0d digits, radix 0..31 with clamping,",
               values_taken, digits_checked);
      $display("zero and full-width values, random gaps and a long sink hold-off");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
